>>> design/wfu_pkg.sv
`default_nettype none
package wfu_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'h81;
  localparam logic [6:0] LEN_EXT16   = 7'd126;
  localparam logic [6:0] LEN_EXT64   = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [2:0] KEY_BYTES   = 3'd4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_HDR  = 2'd1,
    ST_NO_MASK  = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_LEN    = 5'b00010,
    PH_EXT    = 5'b00100,
    PH_KEY    = 5'b01000,
    PH_DATA   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_present;
    logic       frame_end;
    status_e    status;
  } out_item_t;

endpackage
`default_nettype wire

>>> design/websocket_frame_unmasker.sv
`default_nettype none
// Byte-serial unmasker for client-to-server WebSocket frames (final text frame,
// masked). One frame byte is taken per cycle while in_stall_o is low: the header, length,
// extended length and key bytes only update state, and each payload byte is
// XORed with its key byte and produces one result in the same cycle it is
// taken. Results land in an output register backed by one skid entry, so a
// stalled output costs nothing until both are full; in_stall_o rises only while
// the skid entry holds a result. Header errors and a missing mask bit give a
// single result with frame_end set; an empty payload gives one result with no
// byte. LEN_BITS sets the width of the length counter (extended lengths keep
// their low LEN_BITS bits).
module websocket_frame_unmasker
  import wfu_pkg::*;
#(
  parameter int LEN_BITS = 64
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  phase_e              phase_q, phase_d;
  logic [3:0]          ext_left_q, ext_left_d;
  logic [LEN_BITS-1:0] rem_len_q, rem_len_d;
  logic [31:0]         mask_key_q, mask_key_d;
  logic [2:0]          key_left_q, key_left_d;
  logic [1:0]          key_idx_q, key_idx_d;

  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q;

  logic      accept;
  logic      res_valid;
  out_item_t res;
  phase_e    phase_eff;
  logic [7:0] b;
  logic [7:0] key_byte;

  assign in_stall_o = skid_valid_q;
  assign accept     = in_valid_i && !skid_valid_q;
  assign b          = in_data_i.frame_byte;
  assign phase_eff  = in_data_i.restart ? PH_HEADER : phase_q;

  always_comb begin
    unique case (key_idx_q)
      2'd0: key_byte = mask_key_q[31:24];
      2'd1: key_byte = mask_key_q[23:16];
      2'd2: key_byte = mask_key_q[15:8];
      default: key_byte = mask_key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    ext_left_d = ext_left_q;
    rem_len_d  = rem_len_q;
    mask_key_d = mask_key_q;
    key_left_d = key_left_q;
    key_idx_d  = key_idx_q;
    res_valid  = 1'b0;
    res        = '{payload_byte: 8'd0, byte_present: 1'b0, frame_end: 1'b0, status: ST_OK};
    if (in_data_i.restart) begin
      phase_d    = PH_HEADER;
      ext_left_d = '0;
      rem_len_d  = '0;
      mask_key_d = '0;
      key_left_d = '0;
      key_idx_d  = '0;
    end
    unique case (phase_eff)
      PH_HEADER: begin
        if (b != HEADER_BYTE) begin
          res_valid     = 1'b1;
          res.frame_end = 1'b1;
          res.status    = ST_BAD_HDR;
        end else begin
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        rem_len_d = '0;
        if (!b[7]) begin
          phase_d       = PH_HEADER;
          res_valid     = 1'b1;
          res.frame_end = 1'b1;
          res.status    = ST_NO_MASK;
        end else if (b[6:0] == LEN_EXT16) begin
          ext_left_d = EXT16_BYTES;
          phase_d    = PH_EXT;
        end else if (b[6:0] == LEN_EXT64) begin
          ext_left_d = EXT64_BYTES;
          phase_d    = PH_EXT;
        end else begin
          rem_len_d  = LEN_BITS'(b[6:0]);
          phase_d    = PH_KEY;
          key_left_d = KEY_BYTES;
          mask_key_d = '0;
        end
      end
      PH_EXT: begin
        rem_len_d  = {rem_len_q[LEN_BITS-9:0], b};
        ext_left_d = ext_left_q - 4'd1;
        if (ext_left_q == 4'd1) begin
          phase_d    = PH_KEY;
          key_left_d = KEY_BYTES;
          mask_key_d = '0;
        end
      end
      PH_KEY: begin
        mask_key_d = {mask_key_q[23:0], b};
        key_left_d = key_left_q - 3'd1;
        if (key_left_q == 3'd1) begin
          key_idx_d = '0;
          if (rem_len_q == '0) begin
            phase_d       = PH_HEADER;
            res_valid     = 1'b1;
            res.frame_end = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        key_idx_d        = key_idx_q + 2'd1;
        rem_len_d        = rem_len_q - LEN_BITS'(1);
        res_valid        = 1'b1;
        res.payload_byte = b ^ key_byte;
        res.byte_present = 1'b1;
        if (rem_len_q == LEN_BITS'(1)) begin
          phase_d       = PH_HEADER;
          res.frame_end = 1'b1;
        end
      end
      default: begin
        phase_d    = PH_HEADER;
        ext_left_d = '0;
        rem_len_d  = '0;
        mask_key_d = '0;
        key_left_d = '0;
        key_idx_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      ext_left_q <= '0;
      rem_len_q  <= '0;
      mask_key_q <= '0;
      key_left_q <= '0;
      key_idx_q  <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      ext_left_q <= ext_left_d;
      rem_len_q  <= rem_len_d;
      mask_key_q <= mask_key_d;
      key_left_q <= key_left_d;
      key_idx_q  <= key_idx_d;
    end
  end

  // Output register plus one skid entry; skid drains first.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (accept && res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while output register is empty");

  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      !out_data_o.byte_present && out_data_o.frame_end)
    else $error("error result must end the frame and carry no byte");

  a_empty_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_present |-> out_data_o.payload_byte == 8'd0)
    else $error("payload byte nonzero without a byte present");

  a_data_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_data_i.restart && (phase_q == PH_DATA) |=> out_valid_o)
    else $error("payload byte transfer produced no result");

endmodule
`default_nettype wire

>>> bench/websocket_frame_unmasker_tb.sv
`timescale 1ns / 100ps
module websocket_frame_unmasker_tb;
  import wfu_pkg::*;

  localparam int LEN_BITS     = 64;
  localparam logic [63:0] LEN_MASK = (LEN_BITS >= 64) ? '1 : ((64'd1 << LEN_BITS) - 64'd1);
  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int WHOLE_FRAME  = 32'h7fff_ffff;

  typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_e;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  // decoder state mirrored on the bench side
  phase_e      dec_phase = PH_HEADER;
  logic [3:0]  dec_ext_left = '0;
  logic [63:0] dec_rem_len = '0;
  logic [31:0] dec_key = '0;
  logic [2:0]  dec_key_left = '0;
  logic [1:0]  dec_key_idx = '0;

  out_item_t   unmasked_q[$];
  out_item_t   want;
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  bit          steady = 1'b0;

  websocket_frame_unmasker #(
    .LEN_BITS(LEN_BITS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic void clear_decoder();
    dec_phase    = PH_HEADER;
    dec_ext_left = '0;
    dec_rem_len  = '0;
    dec_key      = '0;
    dec_key_left = '0;
    dec_key_idx  = '0;
  endfunction

  function automatic void start_key();
    dec_phase    = PH_KEY;
    dec_key_left = KEY_BYTES;
    dec_key      = '0;
  endfunction

  // Advances the mirrored decoder by one byte; returns 1 when a result is due.
  function automatic bit unmask_byte(input in_item_t it, output out_item_t res);
    logic [7:0] b;
    logic [7:0] kb;
    b = it.frame_byte;
    res = '0;
    if (it.restart) clear_decoder();
    case (dec_phase)
      PH_HEADER: begin
        if (b != HEADER_BYTE) begin
          res.frame_end = 1'b1;
          res.status    = ST_BAD_HDR;
          return 1'b1;
        end
        dec_phase = PH_LEN;
        return 1'b0;
      end
      PH_LEN: begin
        if (!b[7]) begin
          dec_phase     = PH_HEADER;
          res.frame_end = 1'b1;
          res.status    = ST_NO_MASK;
          return 1'b1;
        end
        dec_rem_len = '0;
        if (b[6:0] == LEN_EXT16) begin
          dec_ext_left = EXT16_BYTES;
          dec_phase    = PH_EXT;
        end else if (b[6:0] == LEN_EXT64) begin
          dec_ext_left = EXT64_BYTES;
          dec_phase    = PH_EXT;
        end else begin
          dec_rem_len = {57'd0, b[6:0]} & LEN_MASK;
          start_key();
        end
        return 1'b0;
      end
      PH_EXT: begin
        dec_rem_len  = {dec_rem_len[55:0], b} & LEN_MASK;
        dec_ext_left = dec_ext_left - 4'd1;
        if (dec_ext_left == '0) start_key();
        return 1'b0;
      end
      PH_KEY: begin
        dec_key      = {dec_key[23:0], b};
        dec_key_left = dec_key_left - 3'd1;
        if (dec_key_left != '0) return 1'b0;
        dec_key_idx = '0;
        if (dec_rem_len == '0) begin
          dec_phase     = PH_HEADER;
          res.frame_end = 1'b1;
          res.status    = ST_OK;
          return 1'b1;
        end
        dec_phase = PH_DATA;
        return 1'b0;
      end
      PH_DATA: begin
        kb          = dec_key[31 - 8 * dec_key_idx -: 8];
        dec_key_idx = dec_key_idx + 2'd1;
        dec_rem_len = (dec_rem_len - 64'd1) & LEN_MASK;
        res.payload_byte = b ^ kb;
        res.byte_present = 1'b1;
        res.status       = ST_OK;
        if (dec_rem_len == '0) begin
          dec_phase     = PH_HEADER;
          res.frame_end = 1'b1;
        end
        return 1'b1;
      end
      default: begin
        clear_decoder();
        return 1'b0;
      end
    endcase
  endfunction

  // Called at a rising edge; returns at the edge where the byte transferred.
  task automatic send_byte(input logic [7:0] b, input logic rs);
    in_item_t  it;
    out_item_t res;
    if (!steady && $urandom_range(0, 99) < 25) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    it.frame_byte = b;
    it.restart    = rs;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (unmask_byte(it, res)) unmasked_q.push_back(res);
  endtask

  // Sends the first 'limit' bytes of a frame: header, length, key, payload.
  task automatic send_frame(input len_form_e form, input logic [63:0] len,
                            input logic [31:0] key, input int n_payload,
                            input int limit, input bit rs);
    logic [7:0] bytes_q[$];
    bytes_q.push_back(HEADER_BYTE);
    case (form)
      FORM_SHORT: bytes_q.push_back({1'b1, len[6:0]});
      FORM_EXT16: begin
        bytes_q.push_back({1'b1, LEN_EXT16});
        bytes_q.push_back(len[15:8]);
        bytes_q.push_back(len[7:0]);
      end
      default: begin
        bytes_q.push_back({1'b1, LEN_EXT64});
        for (int i = 7; i >= 0; i--) bytes_q.push_back(len[8 * i +: 8]);
      end
    endcase
    for (int i = 3; i >= 0; i--) bytes_q.push_back(key[8 * i +: 8]);
    repeat (n_payload) bytes_q.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < bytes_q.size() && i < limit; i++) begin
      send_byte(bytes_q[i], (i == 0) ? rs : 1'b0);
    end
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (unmasked_q.size() != 0);
  endtask

  task automatic test_header_errors();
    send_byte(8'h00, 1'b1);
    send_byte(HEADER_BYTE, 1'b0);
    send_byte(8'h7f, 1'b0);
  endtask

  task automatic test_empty_payload();
    send_frame(FORM_SHORT, 64'd0, 32'hff00_ff00, 0, WHOLE_FRAME, 1'b0);
  endtask

  // all-ones 8-byte length (top bit set too), cut short by a restart
  task automatic test_long_length_restart();
    send_frame(FORM_EXT64, '1, 32'h5a3c_c3a5, 2, WHOLE_FRAME, 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  task automatic test_pause_until_drained();
    send_frame(FORM_EXT16, 64'd3, $urandom, 3, WHOLE_FRAME, 1'b0);
    wait_drain();
    send_frame(FORM_SHORT, 64'd5, $urandom, 5, WHOLE_FRAME, 1'b0);
  endtask

  task automatic test_random_traffic();
    int          start;
    int          kind;
    int          n_pay;
    int          hdr_len;
    len_form_e   form;
    logic [63:0] len;
    logic [7:0]  b;
    bit          need_rs;
    bit          rs;
    start   = items_sent;
    need_rs = 1'b0;
    while (items_sent - start < RANDOM_ITEMS) begin
      steady = (items_sent - start >= 500) && (items_sent - start < 750);
      kind = $urandom_range(0, 99);
      rs   = need_rs || ($urandom_range(0, 3) == 0);
      need_rs = 1'b0;
      if (kind < 70) begin
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          form = FORM_SHORT;
          len  = ($urandom_range(0, 4) == 0) ? 64'($urandom_range(0, 125))
                                              : 64'($urandom_range(0, 10));
        end else if (kind < 8) begin
          form = FORM_EXT16;
          len  = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(256, 300))
                                              : 64'($urandom_range(0, 30));
        end else begin
          form = FORM_EXT64;
          len  = 64'($urandom_range(0, 30));
        end
        send_frame(form, len, $urandom, int'(len), WHOLE_FRAME, rs);
      end else if (kind < 78) begin
        // frame broken off somewhere; the next one must restart
        form = len_form_e'($urandom_range(0, 2));
        case (form)
          FORM_SHORT: begin len = 64'($urandom_range(0, 125)); hdr_len = 6; end
          FORM_EXT16: begin len = 64'($urandom_range(0, 65535)); hdr_len = 8; end
          default:    begin len = {$urandom, $urandom}; hdr_len = 14; end
        endcase
        n_pay = (len < 64'd6) ? int'(len) : $urandom_range(0, 6);
        send_frame(form, len, $urandom, n_pay, $urandom_range(1, hdr_len + n_pay), rs);
        need_rs = 1'b1;
      end else if (kind < 86) begin
        do b = 8'($urandom_range(0, 255)); while (b == HEADER_BYTE);
        send_byte(b, rs);
      end else if (kind < 93) begin
        send_byte(HEADER_BYTE, rs);
        send_byte(8'($urandom_range(0, 127)), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        need_rs = 1'b1;
      end
    end
    steady = 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= !steady && ($urandom_range(0, 99) < 25);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (unmasked_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result transfer: %p", out_data_o);
      end else begin
        want = unmasked_q.pop_front();
        if (out_data_o.payload_byte !== want.payload_byte ||
            out_data_o.byte_present !== want.byte_present ||
            out_data_o.frame_end !== want.frame_end ||
            out_data_o.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"mismatch at cycle %0d: exp byte %02h pres %0b end %0b st %0d,",
                      " got byte %02h pres %0b end %0b st %0d"},
                     cycle_count, want.payload_byte, want.byte_present, want.frame_end,
                     want.status, out_data_o.payload_byte, out_data_o.byte_present,
                     out_data_o.frame_end, out_data_o.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_header_errors();
    test_empty_payload();
    test_long_length_restart();
    test_pause_until_drained();
    test_random_traffic();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (unmasked_q.size() != 0) begin
      mismatch_count++;
      $display("%0d expected results never arrived", unmasked_q.size());
    end
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
